[rtl/core/fth_pkg.sv]
// shared constants, types and cosine table for the flat-top window generator
`default_nettype none
package fth_pkg;

   localparam int INDEX_WIDTH      = 16;
   localparam int COS_TABLE_DEPTH  = 1024;
   localparam int NUM_HARM         = 10;
   localparam int ADDR_W           = $clog2(COS_TABLE_DEPTH);
   localparam int TABLE_HALF       = COS_TABLE_DEPTH / 2;
   localparam int FIELD_W          = 16;
   localparam int STEP_W           = 32;
   localparam int COS_W            = 32;
   localparam int COEF_W           = 25;
   localparam int PROD_W           = COEF_W + 1 + COS_W;
   localparam int SUM_W            = 60;
   localparam int OUT_W            = 25;
   localparam int FRAC_SHIFT       = 34;
   localparam int SHIFTED_W        = SUM_W - FRAC_SHIFT;

   localparam logic [STEP_W-1:0]  STEP_RESET = 32'd65536;
   localparam logic [FIELD_W-1:0] INDEX_MASK = FIELD_W'((64'd1 << INDEX_WIDTH) - 64'd1);
   localparam logic [ADDR_W:0]    HALF_VAL   = (ADDR_W+1)'(TABLE_HALF);
   localparam logic [ADDR_W:0]    DEPTH_VAL  = (ADDR_W+1)'(COS_TABLE_DEPTH);

   localparam logic signed [SUM_W-1:0] ONE_BIAS  = SUM_W'(64'sd1 << 54);
   localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(64'sd1 << 33);
   localparam logic signed [SHIFTED_W-1:0] SAT_MAX = SHIFTED_W'(16777215);
   localparam logic signed [SHIFTED_W-1:0] SAT_MIN = -SHIFTED_W'(16777216);

   // harmonic weights in Q24, index 0 holds the lowest harmonic
   localparam logic [NUM_HARM-1:0][COEF_W-1:0] COEF_Q24 = {
      25'd2, 25'd332, 25'd10478, 25'd136482, 25'd950537,
      25'd4029230, 25'd11203448, 25'd21509654, 25'd30050954, 25'd33316936
   };

   localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;
   localparam longint unsigned SeriesDiv [1:14] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
      64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
   };

   typedef logic signed [COS_W-1:0] cos_table_type [0:TABLE_HALF];

   // taylor series cosine in Q30, evaluated at elaboration
   function automatic cos_table_type build_cos_table();
      cos_table_type    tbl;
      longint unsigned  x;
      longint unsigned  x2;
      longint unsigned  t;
      longint           s;
      longint           r;
      for (int m = 0; m <= TABLE_HALF; m++) begin
         x  = (TWO_PI_Q28 * longint'(m) + longint'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
         x2 = (x * x + (64'd1 << 27)) >> 28;
         t  = 64'd1 << 28;
         s  = longint'(t);
         for (int n = 1; n <= 14; n++) begin
            t = ((t * x2) >> 28) / SeriesDiv[n];
            if (n % 2 == 1) begin
               s = s - longint'(t);
            end else begin
               s = s + longint'(t);
            end
         end
         r = s * 4;
         if (r > (64'sd1 << 30)) begin
            r = 64'sd1 << 30;
         end
         if (r < -(64'sd1 << 30)) begin
            r = -(64'sd1 << 30);
         end
         tbl[m] = COS_W'(r);
      end
      return tbl;
   endfunction

   localparam cos_table_type COS_TABLE = build_cos_table();

   typedef struct packed {
      logic                            valid;
      logic [FIELD_W-1:0]              index;
      logic [NUM_HARM-1:0][ADDR_W-1:0] addr;
   } addr_beat_type;

   typedef struct packed {
      logic                           valid;
      logic [FIELD_W-1:0]             index;
      logic [NUM_HARM-1:0][COS_W-1:0] cos;
   } cos_beat_type;

endpackage
`default_nettype wire

[rtl/core/fth_cos_rom.sv]
// cosine lookup rom with registered read
`default_nettype none
module fth_cos_rom (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [fth_pkg::ADDR_W-1:0]  addr,
   output logic signed [fth_pkg::COS_W-1:0] data_ff
);

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= fth_pkg::COS_TABLE[addr];
      end
   end

endmodule
`default_nettype wire

[rtl/core/fth_phase.sv]
// base phase multiply and per-harmonic table address stages
`default_nettype none
module fth_phase (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [fth_pkg::FIELD_W-1:0]  req_sample_index,
   input  wire logic [fth_pkg::STEP_W-1:0]   phase_step,
   input  wire logic                         down_ready,
   output fth_pkg::addr_beat_type            beat_ff
);

   logic                          valid1_ff;
   logic [fth_pkg::FIELD_W-1:0]   index1_ff;
   logic [fth_pkg::STEP_W-1:0]    base1_ff;
   logic [fth_pkg::STEP_W-1:0]    base1_in;
   logic [fth_pkg::FIELD_W+fth_pkg::STEP_W-1:0] base_prod;
   logic                          ready1;
   logic                          ready2;
   fth_pkg::addr_beat_type        beat_in;
   logic [fth_pkg::NUM_HARM-1:0][fth_pkg::STEP_W-1:0] phase;
   logic [fth_pkg::NUM_HARM-1:0][fth_pkg::ADDR_W:0]   slot;
   logic                          addr_ok;

   assign ready2    = !beat_ff.valid || down_ready;
   assign ready1    = !valid1_ff || ready2;
   assign req_stall = !ready1;

   assign base_prod = {{fth_pkg::STEP_W{1'b0}}, req_sample_index & fth_pkg::INDEX_MASK}
                    * {{fth_pkg::FIELD_W{1'b0}}, phase_step};
   assign base1_in  = base_prod[fth_pkg::STEP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (ready1) begin
         valid1_ff <= req_valid;
      end
      if (ready1) begin
         index1_ff <= req_sample_index;
         base1_ff  <= base1_in;
      end
   end

   // nearest table point, folded onto the half turn
   always_comb begin
      beat_in.valid = valid1_ff;
      beat_in.index = index1_ff;
      for (int h = 0; h < fth_pkg::NUM_HARM; h++) begin
         phase[h] = base1_ff * fth_pkg::STEP_W'(h + 1);
         slot[h]  = {1'b0, phase[h][fth_pkg::STEP_W-1 -: fth_pkg::ADDR_W]}
                  + (fth_pkg::ADDR_W+1)'(phase[h][fth_pkg::STEP_W-1-fth_pkg::ADDR_W]);
         if (slot[h] <= fth_pkg::HALF_VAL) begin
            beat_in.addr[h] = slot[h][fth_pkg::ADDR_W-1:0];
         end else begin
            beat_in.addr[h] = fth_pkg::ADDR_W'(fth_pkg::DEPTH_VAL - slot[h]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (ready2) begin
         beat_ff.valid <= beat_in.valid;
      end
      if (ready2) begin
         beat_ff.index <= beat_in.index;
         beat_ff.addr  <= beat_in.addr;
      end
   end

   always_comb begin
      addr_ok = 1'b1;
      for (int h = 0; h < fth_pkg::NUM_HARM; h++) begin
         if ({1'b0, beat_ff.addr[h]} > fth_pkg::HALF_VAL) begin
            addr_ok = 1'b0;
         end
      end
   end

   a_addr_in_table: assert property (@(posedge clock) disable iff (reset)
      beat_ff.valid |-> addr_ok)
      else $error("table address beyond half turn");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !valid1_ff && !beat_ff.valid)
      else $error("pipeline valid survived reset");

endmodule
`default_nettype wire

[rtl/core/fth_sum.sv]
// weighted harmonic products, adder tree, rounding and saturation
`default_nettype none
module fth_sum (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fth_pkg::cos_beat_type         beat,
   output logic                               up_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [fth_pkg::OUT_W-1:0]   rsp_window_value,
   output logic [fth_pkg::FIELD_W-1:0]        rsp_index_echo
);

   typedef logic signed [fth_pkg::SUM_W-1:0] acc_type;

   logic                         valid4_ff, valid5_ff, valid6_ff, valid7_ff, valid8_ff;
   logic [fth_pkg::FIELD_W-1:0]  index4_ff, index5_ff, index6_ff, index7_ff, index8_ff;
   logic                         ready4, ready5, ready6, ready7, ready8;
   acc_type                      term_ff [fth_pkg::NUM_HARM];
   acc_type                      term_in [fth_pkg::NUM_HARM];
   acc_type                      pair_ff [fth_pkg::NUM_HARM/2];
   acc_type                      quad_ff [3];
   acc_type                      half_ff [2];
   acc_type                      total;
   logic signed [fth_pkg::PROD_W-1:0]    prod [fth_pkg::NUM_HARM];
   logic signed [fth_pkg::SUM_W-1:0]     rounded;
   logic signed [fth_pkg::SHIFTED_W-1:0] shifted;
   logic signed [fth_pkg::OUT_W-1:0]     value_in;
   logic signed [fth_pkg::OUT_W-1:0]     value8_ff;

   assign ready8   = !valid8_ff || !rsp_stall;
   assign ready7   = !valid7_ff || ready8;
   assign ready6   = !valid6_ff || ready7;
   assign ready5   = !valid5_ff || ready6;
   assign ready4   = !valid4_ff || ready5;
   assign up_ready = ready4;

   always_comb begin
      for (int h = 0; h < fth_pkg::NUM_HARM; h++) begin
         prod[h]    = $signed({1'b0, fth_pkg::COEF_Q24[h]}) * $signed(beat.cos[h]);
         term_in[h] = fth_pkg::SUM_W'(prod[h]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
         valid7_ff <= 1'b0;
         valid8_ff <= 1'b0;
      end else begin
         if (ready4) valid4_ff <= beat.valid;
         if (ready5) valid5_ff <= valid4_ff;
         if (ready6) valid6_ff <= valid5_ff;
         if (ready7) valid7_ff <= valid6_ff;
         if (ready8) valid8_ff <= valid7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         index4_ff <= beat.index;
         term_ff   <= term_in;
      end
      // odd harmonics enter with minus sign
      if (ready5) begin
         index5_ff <= index4_ff;
         for (int p = 0; p < fth_pkg::NUM_HARM/2; p++) begin
            pair_ff[p] <= term_ff[2*p+1] - term_ff[2*p];
         end
      end
      if (ready6) begin
         index6_ff  <= index5_ff;
         quad_ff[0] <= pair_ff[0] + pair_ff[1];
         quad_ff[1] <= pair_ff[2] + pair_ff[3];
         quad_ff[2] <= pair_ff[4] + fth_pkg::ONE_BIAS;
      end
      if (ready7) begin
         index7_ff  <= index6_ff;
         half_ff[0] <= quad_ff[0] + quad_ff[1];
         half_ff[1] <= quad_ff[2];
      end
      if (ready8) begin
         index8_ff <= index7_ff;
         value8_ff <= value_in;
      end
   end

   // round half up to q20, then clamp
   always_comb begin
      total   = half_ff[0] + half_ff[1];
      rounded = (total + fth_pkg::ROUND_ADD) >>> fth_pkg::FRAC_SHIFT;
      shifted = rounded[fth_pkg::SHIFTED_W-1:0];
      if (shifted > fth_pkg::SAT_MAX) begin
         value_in = fth_pkg::OUT_W'(fth_pkg::SAT_MAX);
      end else if (shifted < fth_pkg::SAT_MIN) begin
         value_in = fth_pkg::OUT_W'(fth_pkg::SAT_MIN);
      end else begin
         value_in = shifted[fth_pkg::OUT_W-1:0];
      end
   end

   assign rsp_valid        = valid8_ff;
   assign rsp_window_value = value8_ff;
   assign rsp_index_echo   = index8_ff;

   a_hold_products: assert property (@(posedge clock) disable iff (reset)
      valid4_ff && !ready4 |=> valid4_ff && $stable(index4_ff))
      else $error("held product beat changed");

endmodule
`default_nettype wire

[rtl/core/flat_top_window_generator.sv]
// top level of the flat-top window coefficient generator
// request path: phase, address, rom, product, pair, quad, half and output registers
// throughput: one coefficient per cycle while rsp_stall is low, set by the 8-stage pipeline
// a response stall holds the pipeline only where beats are queued behind it
// reset (synchronous, active high) empties the pipeline and sets phase_step to 65536
// the cosine table is constant and needs no fill after reset
`default_nettype none
module flat_top_window_generator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [fth_pkg::STEP_W-1:0]    csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [fth_pkg::FIELD_W-1:0]   req_sample_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [fth_pkg::OUT_W-1:0]   rsp_window_value,
   output logic [fth_pkg::FIELD_W-1:0]        rsp_index_echo
);

   logic [fth_pkg::STEP_W-1:0]  phase_step_ff;
   fth_pkg::addr_beat_type      addr_beat;
   fth_pkg::cos_beat_type       cos_beat;
   logic                        valid3_ff;
   logic [fth_pkg::FIELD_W-1:0] index3_ff;
   logic                        ready3;
   logic                        sum_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= fth_pkg::STEP_RESET;
      end else if (csr_wr_en) begin
         phase_step_ff <= csr_wr_data;
      end
   end

   fth_phase u_phase (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_index (req_sample_index),
      .phase_step       (phase_step_ff),
      .down_ready       (ready3),
      .beat_ff          (addr_beat)
   );

   assign ready3 = !valid3_ff || sum_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else if (ready3) begin
         valid3_ff <= addr_beat.valid;
      end
      if (ready3) begin
         index3_ff <= addr_beat.index;
      end
   end

   for (genvar h = 0; h < fth_pkg::NUM_HARM; h++) begin : g_rom
      fth_cos_rom u_rom (
         .clock   (clock),
         .en      (ready3),
         .addr    (addr_beat.addr[h]),
         .data_ff (cos_beat.cos[h])
      );
   end

   assign cos_beat.valid = valid3_ff;
   assign cos_beat.index = index3_ff;

   fth_sum u_sum (
      .clock            (clock),
      .reset            (reset),
      .beat             (cos_beat),
      .up_ready         (sum_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_value (rsp_window_value),
      .rsp_index_echo   (rsp_index_echo)
   );

   a_empty_out_takes: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output stage");

endmodule
`default_nettype wire

[bench/flat_top_window_checker.sv]
// beat monitor, coefficient predictor and comparator for the flat-top window generator
module flat_top_window_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [fth_pkg::STEP_W-1:0]    csr_wr_data,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [fth_pkg::FIELD_W-1:0]   req_sample_index,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic signed [fth_pkg::OUT_W-1:0] rsp_window_value,
   input  wire logic [fth_pkg::FIELD_W-1:0]   rsp_index_echo,
   output int                                 mismatch_count,
   output int                                 coefs_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int    LUT_DEPTH = fth_pkg::COS_TABLE_DEPTH;
   localparam longint SAT_HI   = 64'sd16777215;
   localparam longint SAT_LO   = -64'sd16777216;

   typedef struct packed {
      logic signed [fth_pkg::OUT_W-1:0] value;
      logic [fth_pkg::FIELD_W-1:0]      echo;
   } coef_beat_type;

   coef_beat_type     expected_coefs [$];
   logic signed [31:0] cos_lut [0:LUT_DEPTH-1];
   logic [fth_pkg::STEP_W-1:0] phase_step_copy;

   // Q24 weights of the ten harmonics
   function automatic longint harm_weight(input int k);
      case (k)
         1:       return 64'sd33316936;
         2:       return 64'sd30050954;
         3:       return 64'sd21509654;
         4:       return 64'sd11203448;
         5:       return 64'sd4029230;
         6:       return 64'sd950537;
         7:       return 64'sd136482;
         8:       return 64'sd10478;
         9:       return 64'sd332;
         default: return 64'sd2;
      endcase
   endfunction

   // Q30 cosine of 2*pi*m/depth by a truncated taylor series in Q28
   function automatic logic signed [31:0] series_cos_q30(input longint unsigned m);
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint          acc;
      longint          scaled;
      ang    = (64'd1686629713 * m + LUT_DEPTH / 2) / LUT_DEPTH;
      ang_sq = (ang * ang + (64'd1 << 27)) >> 28;
      term   = 64'd1 << 28;
      acc    = longint'(term);
      for (int n = 1; n <= 14; n++) begin
         term = ((term * ang_sq) >> 28) / longint'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      scaled = acc * 4;
      if (scaled > (64'sd1 <<< 30)) begin
         scaled = 64'sd1 <<< 30;
      end
      if (scaled < -(64'sd1 <<< 30)) begin
         scaled = -(64'sd1 <<< 30);
      end
      return scaled[31:0];
   endfunction

   function automatic coef_beat_type window_coef(input logic [fth_pkg::FIELD_W-1:0] sample,
                                                 input logic [fth_pkg::STEP_W-1:0]  step);
      longint unsigned idx;
      longint unsigned base;
      longint unsigned phase;
      longint unsigned slot;
      longint          acc;
      longint          term;
      longint          q20;
      coef_beat_type   beat;
      idx  = longint'(sample) & ((64'd1 << fth_pkg::INDEX_WIDTH) - 64'd1);
      base = (idx * longint'(step)) & 64'hFFFF_FFFF;
      acc  = 64'sd1 <<< 54;
      for (int k = 1; k <= 10; k++) begin
         phase = (base * longint'(k)) & 64'hFFFF_FFFF;
         slot  = (phase * LUT_DEPTH + (64'd1 << 31)) >> 32;
         if (slot >= LUT_DEPTH) begin
            slot = 0;
         end
         term = harm_weight(k) * longint'(cos_lut[int'(slot)]);
         if (k % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      // Q54 to Q20, halves go up
      q20 = (acc + (64'sd1 <<< 33)) >>> 34;
      if (q20 > SAT_HI) begin
         q20 = SAT_HI;
      end
      if (q20 < SAT_LO) begin
         q20 = SAT_LO;
      end
      beat.value = q20[fth_pkg::OUT_W-1:0];
      beat.echo  = sample;
      return beat;
   endfunction

   initial begin
      for (int j = 0; j < LUT_DEPTH; j++) begin
         cos_lut[j] = series_cos_q30((2 * j <= LUT_DEPTH) ? j : LUT_DEPTH - j);
      end
   end

   always @(posedge clock) begin : watch
      coef_beat_type want;
      int            errs;
      errs = 0;
      if (reset) begin
         phase_step_copy <= fth_pkg::STEP_RESET;
         expected_coefs.delete();
         mismatch_count  <= 0;
         coefs_pending   <= 0;
      end else begin
         if (csr_wr_en) begin
            phase_step_copy <= csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_coefs.size() == 0) begin
               errs++;
               $display("%0t: unexpected response beat, expected none, got value %0d index %0d",
                        $time, rsp_window_value, rsp_index_echo);
            end else begin
               want = expected_coefs.pop_front();
               if (rsp_window_value !== want.value) begin
                  errs++;
                  $display("%0t: window_value for index %0d, expected %0d, got %0d",
                           $time, want.echo, want.value, rsp_window_value);
               end
               if (rsp_index_echo !== want.echo) begin
                  errs++;
                  $display("%0t: index_echo, expected %0d, got %0d",
                           $time, want.echo, rsp_index_echo);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_coefs.push_back(window_coef(req_sample_index, phase_step_copy));
         end
         mismatch_count <= mismatch_count + errs;
         coefs_pending  <= expected_coefs.size();
      end
   end

endmodule

[bench/flat_top_window_generator_tb.sv]
// stimulus, receiver stalls and verdict for the flat-top window generator
module flat_top_window_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 60;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_style_type;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          csr_wr_en        = 1'b0;
   logic [fth_pkg::STEP_W-1:0]    csr_wr_data      = '0;
   logic                          req_valid        = 1'b0;
   logic [fth_pkg::FIELD_W-1:0]   req_sample_index = '0;
   logic                          rsp_stall        = 1'b0;
   logic                          req_stall;
   logic                          rsp_valid;
   logic signed [fth_pkg::OUT_W-1:0] rsp_window_value;
   logic [fth_pkg::FIELD_W-1:0]   rsp_index_echo;

   int              mismatch_count;
   int              coefs_pending;
   stall_style_type stall_style = STALL_NONE;
   int              hold_seq    = 0;
   int              hold_seen   = 0;
   int              hold_left   = 0;
   int              comb_phase  = 0;
   int              burst_left  = 0;
   int              max_gap     = 0;
   int              cycle_count = 0;

   always #5 clock = ~clock;

   flat_top_window_generator DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_value (rsp_window_value),
      .rsp_index_echo   (rsp_index_echo)
   );

   flat_top_window_checker coef_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_value (rsp_window_value),
      .rsp_index_echo   (rsp_index_echo),
      .mismatch_count   (mismatch_count),
      .coefs_pending    (coefs_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("flat_top_window_generator_tb: done, errors");
         $finish;
      end
   end

   // receiver: a long hold when asked, otherwise the current stall pattern
   always @(posedge clock) begin
      comb_phase <= (comb_phase + 1) % 7;
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left != 1);
      end else begin
         case (stall_style)
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
            STALL_COMB:  rsp_stall <= (comb_phase < 3);
            default:     rsp_stall <= 1'b0;
         endcase
      end
   end

   function automatic logic [fth_pkg::STEP_W-1:0] step_for(input longint unsigned len);
      return fth_pkg::STEP_W'(((64'd1 << 32) + len / 2) / len);
   endfunction

   task automatic offer_index(input logic [fth_pkg::FIELD_W-1:0] idx);
      int gap;
      req_valid        <= 1'b1;
      req_sample_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (coefs_pending != 0) @(posedge clock);
   endtask

   task automatic write_phase_step(input logic [fth_pkg::STEP_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(input logic [fth_pkg::STEP_W-1:0] step, input int win,
                            input int count, input stall_style_type style,
                            input int gap_max, input bit long_hold);
      int pick;
      int seq_idx;
      logic [fth_pkg::FIELD_W-1:0] idx;
      seq_idx = 0;
      write_phase_step(step);
      stall_style <= style;
      max_gap = long_hold ? 0 : gap_max;
      for (int i = 0; i < count; i++) begin
         // keep beats coming while the receiver holds off so the pipe fills
         if (long_hold && i == count / 4) begin
            hold_seq <= hold_seq + 1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            idx     = fth_pkg::FIELD_W'(seq_idx % win);
            seq_idx = seq_idx + 1;
         end else if (pick < 7) begin
            idx = fth_pkg::FIELD_W'($urandom_range(0, win - 1));
         end else begin
            idx = fth_pkg::FIELD_W'($urandom);
         end
         offer_index(idx);
      end
   endtask

   initial begin : stimulus
      int win_len;
      repeat (4) @(posedge clock);
      reset       <= 1'b0;
      stall_style <= STALL_LIGHT;
      max_gap     = 3;

      // reset value of phase_step
      offer_index(16'h0000);
      offer_index(16'h0001);
      offer_index(16'h7FFF);
      offer_index(16'h8000);
      offer_index(16'hFFFF);
      offer_index(16'h5555);
      offer_index(16'hAAAA);
      // zero step gives the window start for every index
      write_phase_step(32'h0000_0000);
      offer_index(16'h0000);
      offer_index(16'hFFFF);
      offer_index(16'h1234);
      write_phase_step(32'hFFFF_FFFF);
      offer_index(16'h0000);
      offer_index(16'h0001);
      offer_index(16'h8000);
      offer_index(16'hFFFF);
      // short window, indices past its end wrap
      write_phase_step(step_for(16));
      offer_index(16'd15);
      offer_index(16'd16);
      offer_index(16'd17);
      offer_index(16'd1000);
      offer_index(16'hFFFF);
      write_phase_step(step_for(7));
      offer_index(16'd0);
      offer_index(16'd3);
      offer_index(16'd6);

      run_phase(step_for(64), 64, 100, STALL_LIGHT, 4, 1'b0);
      run_phase(step_for(1024), 1024, 100, STALL_NONE, 0, 1'b1);
      run_phase($urandom, 65536, 100, STALL_HEAVY, 6, 1'b0);
      win_len = $urandom_range(2, 65535);
      run_phase(step_for(win_len), win_len, 100, STALL_LIGHT, 3, 1'b0);
      run_phase(step_for(3), 3, 80, STALL_COMB, 2, 1'b0);
      run_phase(32'hFFFF_FFFF, 65536, 60, STALL_LIGHT, 3, 1'b0);
      run_phase(32'h0000_0000, 65536, 40, STALL_HEAVY, 2, 1'b0);
      run_phase(step_for(65536), 65536, 100, STALL_LIGHT, 5, 1'b1);
      run_phase($urandom, 65536, 100, STALL_NONE, 0, 1'b0);

      drain_results();
      repeat (20) @(posedge clock);
      if (coefs_pending != 0) begin
         $display("%0t: %0d coefficients never came back", $time, coefs_pending);
      end
      if (mismatch_count == 0 && coefs_pending == 0) begin
         $display("flat_top_window_generator_tb: done, clean");
      end else begin
         $display("flat_top_window_generator_tb: done, errors");
      end
      $finish;
   end

endmodule

[flat_top_window_generator.f]
rtl/core/fth_pkg.sv
rtl/core/fth_cos_rom.sv
rtl/core/fth_phase.sv
rtl/core/fth_sum.sv
rtl/core/flat_top_window_generator.sv
bench/flat_top_window_checker.sv
bench/flat_top_window_generator_tb.sv
